// ----- rtl/omni_wheel_inverse_kinematics_top_macros.svh -----
// Assertion macros for the omni wheel inverse kinematics block.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef OMNI_WHEEL_INVERSE_KINEMATICS_TOP_MACROS_SVH
`define OMNI_WHEEL_INVERSE_KINEMATICS_TOP_MACROS_SVH

// same-cycle implication, inactive during reset
`define OWIK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, inactive during reset
`define OWIK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/owik_pkg.sv -----
// Shared types and constants for the omni wheel inverse kinematics block.
// No dependencies.
package owik_pkg;

  localparam int VelW      = 16;
  localparam int RadW      = 16;
  localparam int LimW      = 15;
  localparam int ProdW     = 33;  // Q0.16 * Q5.10, signed
  localparam int WheelW    = 19;  // wheel sums before limiting
  localparam int MagW      = 18;  // wheel magnitude
  localparam int QuoW      = 15;  // scaled magnitude never exceeds the limit
  localparam int NumW      = MagW + LimW;
  localparam int NumLoW    = NumW - MagW;
  localparam int NumWheels = 4;
  localparam int DivSteps  = QuoW;
  localparam int FrontDepth = 4;
  localparam int PipeDepth = FrontDepth + DivSteps + 1;
  localparam int PendW     = $clog2(PipeDepth + 1);

  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 16;

  localparam logic [CfgIdxW-1:0] CfgRadius   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxSpeed = 2'd1;

  localparam logic [RadW-1:0] RadiusReset   = 16'd19661;
  localparam logic [LimW-1:0] MaxSpeedReset = 15'd14336;

  typedef struct packed {
    logic signed [VelW-1:0] vel_x;
    logic signed [VelW-1:0] vel_y;
    logic signed [VelW-1:0] yaw_rate;
  } cmd_t;

  typedef struct packed {
    logic signed [VelW-1:0] wheel_zero_speed;
    logic signed [VelW-1:0] wheel_one_speed;
    logic signed [VelW-1:0] wheel_two_speed;
    logic signed [VelW-1:0] wheel_three_speed;
    logic                   was_scaled;
  } wheel_set_t;

  // one wheel inside the restoring divider
  typedef struct packed {
    logic              neg;
    logic [VelW-1:0]   raw;     // unscaled speed, used when no limiting
    logic [MagW-1:0]   rem;
    logic [NumLoW-1:0] num_lo;  // numerator bits not yet shifted in
    logic [QuoW-1:0]   quo;
  } lane_t;

  typedef struct packed {
    lane_t [NumWheels-1:0] lane;
    logic  [MagW-1:0]      den;
    logic                  scaled;
  } div_t;

endpackage

// ----- rtl/owik_front.sv -----
// Front pipeline: rotation product, wheel sums, peak magnitude, scale numerators.
// Four register stages; depends on owik_pkg.
module owik_front import owik_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [RadW-1:0] radius,
  input  logic [LimW-1:0] lim,
  input  logic            up_valid,
  input  cmd_t            up_data,
  output logic            up_stall,
  output logic            dn_valid,
  output div_t            dn_data,
  input  logic            dn_stall
);

  logic [FrontDepth-1:0] v_r;
  logic [FrontDepth-1:0] stall;

  // stage A
  logic signed [VelW-1:0]  vx_a_r, vy_a_r;
  logic signed [ProdW-1:0] prod_a_r, prod_nxt;
  // stage B
  logic signed [WheelW-1:0] w_b_r [NumWheels];
  logic signed [WheelW-1:0] w_nxt [NumWheels];
  logic signed [WheelW-1:0] rot, vx_e, vy_e;
  // stage C
  logic [MagW-1:0] mag_c_r [NumWheels];
  logic [MagW-1:0] mag_nxt [NumWheels];
  logic [WheelW-1:0] abs_w [NumWheels];
  logic [NumWheels-1:0] neg_c_r, neg_nxt;
  logic [VelW-1:0] raw_c_r [NumWheels];
  logic [MagW-1:0] big01, big23, big_nxt, big_c_r;
  logic scl_c_r, scl_nxt;
  // stage D
  div_t d_r, d_nxt;
  logic [NumW-1:0] num [NumWheels];

  always_comb begin
    stall[FrontDepth-1] = v_r[FrontDepth-1] && dn_stall;
    for (int k = FrontDepth - 2; k >= 0; k--) begin
      stall[k] = v_r[k] && stall[k+1];
    end
  end
  assign up_stall = stall[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (!stall[0]) v_r[0] <= up_valid;
      for (int k = 1; k < FrontDepth; k++) begin
        if (!stall[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign prod_nxt = $signed({1'b0, radius}) * up_data.yaw_rate;

  always_ff @(posedge clk) begin
    if (!stall[0]) begin
      vx_a_r   <= up_data.vel_x;
      vy_a_r   <= up_data.vel_y;
      prod_a_r <= prod_nxt;
    end
  end

  // floor shift by 14 is the upper bits of the product
  assign rot  = prod_a_r[ProdW-1:ProdW-WheelW];
  assign vx_e = WheelW'(vx_a_r);
  assign vy_e = WheelW'(vy_a_r);

  always_comb begin
    w_nxt[0] = vy_e + rot;
    w_nxt[1] = rot - vx_e;
    w_nxt[2] = rot - vy_e;
    w_nxt[3] = vx_e + rot;
  end

  always_ff @(posedge clk) begin
    if (!stall[1]) begin
      for (int i = 0; i < NumWheels; i++) w_b_r[i] <= w_nxt[i];
    end
  end

  always_comb begin
    for (int i = 0; i < NumWheels; i++) begin
      neg_nxt[i] = w_b_r[i][WheelW-1];
      abs_w[i]   = neg_nxt[i] ? WheelW'(-w_b_r[i]) : WheelW'(w_b_r[i]);
      mag_nxt[i] = abs_w[i][MagW-1:0];
    end
    big01   = (mag_nxt[0] > mag_nxt[1]) ? mag_nxt[0] : mag_nxt[1];
    big23   = (mag_nxt[2] > mag_nxt[3]) ? mag_nxt[2] : mag_nxt[3];
    big_nxt = (big01 > big23) ? big01 : big23;
    scl_nxt = big_nxt > MagW'(lim);
  end

  always_ff @(posedge clk) begin
    if (!stall[2]) begin
      for (int i = 0; i < NumWheels; i++) begin
        mag_c_r[i] <= mag_nxt[i];
        raw_c_r[i] <= w_b_r[i][VelW-1:0];
      end
      neg_c_r <= neg_nxt;
      big_c_r <= big_nxt;
      scl_c_r <= scl_nxt;
    end
  end

  // numerator |w| * limit, split into the starting remainder and bits to shift in
  always_comb begin
    d_nxt.den    = big_c_r;
    d_nxt.scaled = scl_c_r;
    for (int i = 0; i < NumWheels; i++) begin
      num[i] = NumW'(mag_c_r[i]) * NumW'(lim);
      d_nxt.lane[i].neg    = neg_c_r[i];
      d_nxt.lane[i].raw    = raw_c_r[i];
      d_nxt.lane[i].rem    = num[i][NumW-1:NumLoW];
      d_nxt.lane[i].num_lo = num[i][NumLoW-1:0];
      d_nxt.lane[i].quo    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall[3]) d_r <= d_nxt;
  end

  assign dn_valid = v_r[FrontDepth-1];
  assign dn_data  = d_r;

endmodule

// ----- rtl/owik_div_step.sv -----
// One restoring-division step for all four wheels, one quotient bit each.
// Depends on owik_pkg.
module owik_div_step import owik_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  input  div_t up_data,
  output logic up_stall,
  output logic dn_valid,
  input  logic dn_stall,
  output div_t dn_data
);

  logic v_r;
  div_t d_r, d_nxt;
  logic [MagW:0] trial [NumWheels];
  logic [MagW:0] diff  [NumWheels];
  logic [NumWheels-1:0] fits;

  assign up_stall = v_r && dn_stall;

  always_comb begin
    d_nxt = up_data;
    for (int i = 0; i < NumWheels; i++) begin
      trial[i] = {up_data.lane[i].rem, up_data.lane[i].num_lo[NumLoW-1]};
      diff[i]  = trial[i] - {1'b0, up_data.den};
      fits[i]  = trial[i] >= {1'b0, up_data.den};
      d_nxt.lane[i].rem    = fits[i] ? diff[i][MagW-1:0] : trial[i][MagW-1:0];
      d_nxt.lane[i].num_lo = {up_data.lane[i].num_lo[NumLoW-2:0], 1'b0};
      d_nxt.lane[i].quo    = {up_data.lane[i].quo[QuoW-2:0], fits[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (!up_stall) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall) d_r <= d_nxt;
  end

  assign dn_valid = v_r;
  assign dn_data  = d_r;

endmodule

// ----- rtl/omni_wheel_inverse_kinematics_top.sv -----
// Omni wheel inverse kinematics with desaturation: top level.
// Uses owik_pkg, owik_front and owik_div_step.
//
// Input channel in_valid/in_data/in_stall carries one chassis command
// (vel_x, vel_y Q3.12, yaw_rate Q5.10); a transfer happens when in_valid
// is high and in_stall is low. Each command yields one wheel set on
// out_valid/out_data/out_stall with four Q3.12 setpoints and was_scaled.
// Configuration: cfg_valid/cfg_ready (always ready) with cfg_index
// 0 = wheel radius to center, 1 = max wheel speed; other indexes are
// ignored. Write only while no command is in flight.
// The pipeline has four front stages (product, wheel sums, peak
// magnitude, scale multiply), 15 divider stages at one quotient bit each,
// and the output register. Throughput is one command per cycle without stalls.
// Each stage stalls only when it holds an item and the next one stalls,
// so empty stages keep filling while a result waits on out_stall.
// Synchronous reset clears all valid bits and loads the register defaults.
module omni_wheel_inverse_kinematics_top import owik_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  cmd_t                in_data,
  output logic                in_stall,
  output logic                out_valid,
  output wheel_set_t          out_data,
  input  logic                out_stall,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  logic [RadW-1:0] radius_r;
  logic [LimW-1:0] lim_r;

  div_t            dchain [DivSteps+1];
  logic [DivSteps:0] dvalid;
  logic [DivSteps:0] dstall;

  logic       out_valid_r;
  wheel_set_t out_data_r, out_nxt;
  logic       out_hold;
  logic [VelW-1:0] qmag [NumWheels];
  logic [VelW-1:0] wval [NumWheels];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RadiusReset;
      lim_r    <= MaxSpeedReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CfgRadius:   radius_r <= cfg_data[RadW-1:0];
        CfgMaxSpeed: lim_r    <= cfg_data[LimW-1:0];
        default:     ;
      endcase
    end
  end

  owik_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .radius   (radius_r),
    .lim      (lim_r),
    .up_valid (in_valid),
    .up_data  (in_data),
    .up_stall (in_stall),
    .dn_valid (dvalid[0]),
    .dn_data  (dchain[0]),
    .dn_stall (dstall[0])
  );

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    owik_div_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (dvalid[k]),
      .up_data  (dchain[k]),
      .up_stall (dstall[k]),
      .dn_valid (dvalid[k+1]),
      .dn_stall (dstall[k+1]),
      .dn_data  (dchain[k+1])
    );
  end

  assign out_hold         = out_valid_r && out_stall;
  assign dstall[DivSteps] = out_hold;

  // restore sign of the scaled magnitude; unscaled wheels already fit 16 bits
  always_comb begin
    for (int i = 0; i < NumWheels; i++) begin
      qmag[i] = {1'b0, dchain[DivSteps].lane[i].quo};
      wval[i] = dchain[DivSteps].scaled
                ? (dchain[DivSteps].lane[i].neg ? VelW'(-qmag[i]) : qmag[i])
                : dchain[DivSteps].lane[i].raw;
    end
    out_nxt.wheel_zero_speed  = wval[0];
    out_nxt.wheel_one_speed   = wval[1];
    out_nxt.wheel_two_speed   = wval[2];
    out_nxt.wheel_three_speed = wval[3];
    out_nxt.was_scaled        = dchain[DivSteps].scaled;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_hold) begin
      out_valid_r <= dvalid[DivSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_hold) out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/owik_checker.sv -----
// Port-level checker for omni_wheel_inverse_kinematics_top, bound below.
// Depends on owik_pkg and the assertion macro header.
`include "omni_wheel_inverse_kinematics_top_macros.svh"

module owik_checker import owik_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input wheel_set_t out_data
);

  logic [PendW-1:0] pending_r, pending_nxt;
  logic in_xfer, out_xfer;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  always_comb begin
    pending_nxt = pending_r;
    if (in_xfer && !out_xfer) pending_nxt = pending_r + PendW'(1);
    if (!in_xfer && out_xfer) pending_nxt = pending_r - PendW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  `OWIK_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `OWIK_ASSERT_IMP(a_in_stall_cause, in_stall, out_valid && out_stall, "input stalled without output stall")
  `OWIK_ASSERT_IMP(a_no_phantom, out_valid, pending_r != '0, "result without outstanding command")
  `OWIK_ASSERT_IMP(a_occupancy, 1'b1, pending_r <= PendW'(PipeDepth), "more commands in flight than stages")

endmodule

bind omni_wheel_inverse_kinematics_top owik_checker u_owik_checker (.*);

// ----- test/tb_omni_wheel_inverse_kinematics_top.sv -----
// Self-checking testbench for omni_wheel_inverse_kinematics_top: random and corner-case
// chassis commands, with an in-bench wheel speed predictor and per-field result checks.
// Depends on owik_pkg and the RTL top level only.
module tb_omni_wheel_inverse_kinematics_top import owik_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  cmd_t                in_data = '0;
  logic                in_stall;
  logic                out_valid;
  wheel_set_t          out_data;
  logic                out_stall = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  omni_wheel_inverse_kinematics_top DUT (
    .clk, .rst_n,
    .in_valid, .in_data, .in_stall,
    .out_valid, .out_data, .out_stall,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #5 clk = ~clk;

  // bench copy of the registers
  logic [RadW-1:0] radius_q;
  logic [LimW-1:0] limit_q;

  cmd_t       pending_cmds[$];
  wheel_set_t expected_wheels[$];

  logic in_fire = 1'b0;
  int   idle_pct = 0;
  int   in_gap = 0;
  int   stall_left = 0;
  int   reg_writes = 0;
  int   cmd_count = 0;
  int   set_count = 0;
  int   limited_count = 0;
  int   fail_count = 0;

  function automatic wheel_set_t predict_wheels(cmd_t c, logic [RadW-1:0] radius,
                                                logic [LimW-1:0] limit);
    longint     rot;
    longint     peak;
    longint     mag;
    longint     w [4];
    wheel_set_t r;
    rot = (longint'(radius) * longint'(c.yaw_rate)) >>> 14;  // floor shift
    w[0] = longint'(c.vel_y) + rot;
    w[1] = rot - longint'(c.vel_x);
    w[2] = rot - longint'(c.vel_y);
    w[3] = longint'(c.vel_x) + rot;
    peak = 0;
    for (int i = 0; i < 4; i++) begin
      mag = (w[i] < 0) ? -w[i] : w[i];
      if (mag > peak) peak = mag;
    end
    r.was_scaled = (peak > longint'(limit));
    if (r.was_scaled) begin
      // signed divide truncates toward zero
      for (int i = 0; i < 4; i++) w[i] = (w[i] * longint'(limit)) / peak;
    end
    r.wheel_zero_speed  = 16'(w[0]);
    r.wheel_one_speed   = 16'(w[1]);
    r.wheel_two_speed   = 16'(w[2]);
    r.wheel_three_speed = 16'(w[3]);
    return r;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // monitor: predicts on each command transfer, checks each wheel set transfer
  always @(posedge clk) begin
    wheel_set_t want;
    if (!rst_n) begin
      radius_q <= RadiusReset;
      limit_q  <= MaxSpeedReset;
      in_fire  <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        expected_wheels.push_back(predict_wheels(in_data, radius_q, limit_q));
        cmd_count <= cmd_count + 1;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CfgRadius) radius_q <= cfg_data;
        else if (cfg_index == CfgMaxSpeed) limit_q <= cfg_data[LimW-1:0];
        reg_writes <= reg_writes + 1;
      end
      if (out_valid && !out_stall) begin
        if (expected_wheels.size() == 0) begin
          $error("wheel set transfer with nothing expected");
          fail_count++;
        end else begin
          want = expected_wheels.pop_front();
          check_field("wheel_zero_speed", want.wheel_zero_speed, out_data.wheel_zero_speed);
          check_field("wheel_one_speed", want.wheel_one_speed, out_data.wheel_one_speed);
          check_field("wheel_two_speed", want.wheel_two_speed, out_data.wheel_two_speed);
          check_field("wheel_three_speed", want.wheel_three_speed,
                      out_data.wheel_three_speed);
          check_field("was_scaled", want.was_scaled, out_data.was_scaled);
          set_count <= set_count + 1;
          if (want.was_scaled) limited_count <= limited_count + 1;
        end
      end
    end
  end

  // command driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        in_data  <= pending_cmds.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 99) < idle_pct) in_gap = $urandom_range(1, 7);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // wheel set receiver
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (rst_n && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic add_cmd(int vx, int vy, int wz);
    cmd_t c;
    c.vel_x    = 16'(vx);
    c.vel_y    = 16'(vy);
    c.yaw_rate = 16'(wz);
    pending_cmds.push_back(c);
  endtask

  function automatic logic [VelW-1:0] rand_speed();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      1, 2: return 16'($signed($urandom_range(0, 8191)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_random(int n);
    repeat (n) add_cmd(rand_speed(), rand_speed(), rand_speed());
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    int target;
    target = reg_writes + 1;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    while (reg_writes != target) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // sender holds off until the pipe is empty, then lets it settle
  task automatic drain();
    while (pending_cmds.size() != 0 || in_valid || expected_wheels.size() != 0)
      @(posedge clk);
    repeat (PipeDepth + 4) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset register values, corner commands first
    idle_pct = 15;
    add_cmd(0, 0, 0);
    add_cmd(32767, 32767, 32767);
    add_cmd(-32768, -32768, -32768);
    add_cmd(32767, -32768, 0);
    add_cmd(-32768, 32767, 0);
    add_cmd(0, 0, 32767);
    add_cmd(0, 0, -32768);
    add_cmd(0, 0, -1);          // rotation term floors to -2
    add_cmd(0, 0, 1);
    add_cmd(0, 14336, 0);       // peak equal to limit, no scaling
    add_cmd(0, 14337, 0);       // just over the limit
    add_cmd(14336, 0, 0);
    add_cmd(-14337, 0, 0);
    add_cmd(16'h5555, 16'hAAAA, 16'h5555);
    add_cmd(16'hAAAA, 16'h5555, 16'hAAAA);
    add_cmd(100, -200, 300);
    add_cmd(-1, -1, -1);
    add_random(300);
    drain();

    // widest radius, top limit written through the masked upper bit
    idle_pct = 30;
    write_reg(CfgRadius, 16'hFFFF);
    write_reg(CfgMaxSpeed, 16'hFFFF);
    add_cmd(0, 0, 32767);
    add_cmd(0, 0, -32768);
    add_random(250);
    drain();

    // no rotation term, smallest legal limit
    idle_pct = 5;
    write_reg(CfgRadius, 16'h0000);
    write_reg(CfgMaxSpeed, 16'd1);
    add_cmd(0, 0, 12345);
    add_cmd(1, -1, 0);
    add_random(200);
    drain();

    // zero limit; spare indexes must leave the registers alone
    idle_pct = 15;
    write_reg(CfgMaxSpeed, 16'h0000);
    write_reg(CfgRadius, 16'($urandom));
    write_reg(CfgSpareA, 16'($urandom));
    write_reg(CfgSpareB, 16'($urandom));
    add_cmd(0, 0, 0);
    add_cmd(0, 1, 0);
    add_random(100);
    add_cmd(0, 0, 0);
    drain();

    // random settings, back to back at full rate
    idle_pct = 0;
    write_reg(CfgRadius, 16'($urandom));
    write_reg(CfgMaxSpeed, 16'($urandom_range(1, 32767)) | 16'h8000);
    add_random(300);
    drain();

    $display("Checked %0d wheel sets from %0d commands, %0d of them limited.",
             set_count, cmd_count, limited_count);
    $display("Registers swept: radius 0 to 65535, limit 0 to 32767, spare indexes 2 and 3.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/owik_pkg.sv
rtl/owik_front.sv
rtl/owik_div_step.sv
rtl/omni_wheel_inverse_kinematics_top.sv
rtl/owik_checker.sv
test/tb_omni_wheel_inverse_kinematics_top.sv
